>>> hw/rtl/bmwo_pkg.sv
// Shared types and constants for the byte masked write overlay.
// Item structs, slot table command/lookup structs, status and kind codes.
// No dependencies.
package bmwo_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int NUM_SLOTS   = 16;
  localparam int ADDR_W      = 48;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TAG_W       = ADDR_W - OFF_W;
  localparam int SIZE_W      = ADDR_W + 1;
  localparam int RAM_AW      = SLOT_W + OFF_W;
  localparam int RAM_DEPTH   = NUM_SLOTS * BLOCK_BYTES;
  localparam int CFG_IDX_W   = 8;

  // input kinds
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_FLUSH    = 2'd2;
  localparam logic [1:0] KIND_TRUNCATE = 2'd3;

  // result status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NO_PERM  = 3'd3;
  localparam logic [2:0] ST_NOTHING  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PERM  = 8'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        data_byte;
    logic              access_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] out_address;
    logic [7:0]        out_byte;
    logic              hit;
    logic              run_end;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_alloc;
    logic              free_en;
    logic              trunc_en;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  off;
  } slot_cmd_t;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      hit_slot;
    logic [BLOCK_BYTES-1:0] hit_mask;
    logic                   full;
    logic [SLOT_W-1:0]      free_slot;
  } slot_look_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_RD,
    S_FRD,
    S_FEM,
    S_TRUNC,
    S_TEM
  } state_t;

endpackage

>>> hw/rtl/byte_masked_write_overlay.sv
// Top level of the byte masked write overlay: sequencer, config, result register.
// Depends on bmwo_pkg, bmwo_slot_table and bmwo_byte_ram.
//
//  channel  ports                             direction
//  in       in_valid/in_ready/in_item         item in
//  out      out_valid/out_ready/out_item      results out
//  cfg      cfg_valid/cfg_ready/cfg_index/... register writes
//
// Write: the item is registered, then tag match and store write in lookup.
// Read: a miss answers in lookup; a hit issues one store read and answers
// from the read state. Flush: invalid bytes below the last valid one are
// skipped; each valid byte is fetched, then emitted, via the single store
// read port. Truncate: one slot per cycle. A full result register holds the
// sequencer until out_ready. Reset clears the used bits at once.
module byte_masked_write_overlay (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bmwo_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bmwo_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bmwo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmwo_pkg::SIZE_W-1:0]       cfg_data
);

  bmwo_pkg::state_t                 state_r, state_nxt;
  bmwo_pkg::in_item_t               item_r;
  bmwo_pkg::out_item_t              out_item_r, out_item_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bmwo_pkg::SIZE_W-1:0]      dev_size_r;
  logic                             perm_r;
  logic [bmwo_pkg::BLOCK_BYTES-1:0] m_r, m_nxt;
  logic [bmwo_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic [bmwo_pkg::OFF_W-1:0]       idx_r, idx_nxt;

  bmwo_pkg::slot_cmd_t              cmd;
  bmwo_pkg::slot_look_t             look;
  logic [bmwo_pkg::TAG_W-1:0]       blk;
  logic [bmwo_pkg::OFF_W-1:0]       off;
  logic [bmwo_pkg::OFF_W-1:0]       idx_p1;
  logic                             oor;
  logic                             out_free;
  logic                             ram_we, ram_re;
  logic [bmwo_pkg::RAM_AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]                       ram_rdata;
  logic [bmwo_pkg::BLOCK_BYTES-1:0] idx_bit;

  assign blk      = item_r.byte_address[bmwo_pkg::ADDR_W-1:bmwo_pkg::OFF_W];
  assign off      = item_r.byte_address[bmwo_pkg::OFF_W-1:0];
  assign oor      = {1'b0, item_r.byte_address} >= dev_size_r;
  assign out_free = !out_valid_r || out_ready;
  assign idx_p1   = idx_r + 1'b1;
  assign in_ready = state_r == bmwo_pkg::S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  bmwo_slot_table u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .look_tag (blk),
    .dev_size (dev_size_r),
    .cmd      (cmd),
    .look     (look)
  );

  bmwo_byte_ram #(
    .WIDTH (8),
    .DEPTH (bmwo_pkg::RAM_DEPTH),
    .AW    (bmwo_pkg::RAM_AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item_r.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_size_r <= '0;
      perm_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bmwo_pkg::CFG_DEVICE_SIZE) begin
        dev_size_r <= cfg_data;
      end else if (cfg_index == bmwo_pkg::CFG_WRITE_PERM) begin
        perm_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmwo_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
    m_r        <= m_nxt;
    slot_r     <= slot_nxt;
    idx_r      <= idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    m_nxt         = m_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = {look.free_slot, off};
    ram_raddr     = {look.hit_slot, off};
    idx_bit       = '0;
    idx_bit[idx_r] = 1'b1;

    unique case (state_r)
      bmwo_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = bmwo_pkg::S_LOOK;
        end
      end

      bmwo_pkg::S_LOOK: begin
        unique case (item_r.kind)
          bmwo_pkg::KIND_WRITE: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{bmwo_pkg::ST_OK, item_r.byte_address, item_r.data_byte,
                                1'b0, item_r.access_end, 1'b1};
              state_nxt     = bmwo_pkg::S_IDLE;
              if (oor) begin
                out_item_nxt.status   = bmwo_pkg::ST_RANGE;
                out_item_nxt.out_byte = '0;
              end else if (!look.hit && look.full) begin
                out_item_nxt.status   = bmwo_pkg::ST_FULL;
                out_item_nxt.out_byte = '0;
              end else begin
                cmd.wr_en    = 1'b1;
                cmd.wr_alloc = !look.hit;
                cmd.slot     = look.hit ? look.hit_slot : look.free_slot;
                cmd.off      = off;
                ram_we       = 1'b1;
                ram_waddr    = {cmd.slot, off};
              end
            end
          end

          bmwo_pkg::KIND_READ: begin
            if (!oor && look.hit && look.hit_mask[off]) begin
              ram_re    = 1'b1;
              state_nxt = bmwo_pkg::S_RD;
            end else if (out_free) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{bmwo_pkg::ST_OK, item_r.byte_address, item_r.data_byte,
                                1'b0, item_r.access_end, 1'b1};
              if (oor) begin
                out_item_nxt.status   = bmwo_pkg::ST_RANGE;
                out_item_nxt.out_byte = '0;
              end
              state_nxt = bmwo_pkg::S_IDLE;
            end
          end

          bmwo_pkg::KIND_FLUSH: begin
            if (perm_r && look.hit && look.hit_mask != '0) begin
              m_nxt     = look.hit_mask;
              slot_nxt  = look.hit_slot;
              idx_nxt   = '0;
              state_nxt = bmwo_pkg::S_FRD;
            end else if (out_free) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{bmwo_pkg::ST_NOTHING, item_r.byte_address, 8'd0,
                                1'b0, 1'b0, 1'b1};
              if (!perm_r) begin
                out_item_nxt.status = bmwo_pkg::ST_NO_PERM;
              end else if (look.hit) begin
                cmd.free_en = 1'b1;
                cmd.slot    = look.hit_slot;
              end
              state_nxt = bmwo_pkg::S_IDLE;
            end
          end

          bmwo_pkg::KIND_TRUNCATE: begin
            slot_nxt  = '0;
            state_nxt = bmwo_pkg::S_TRUNC;
          end

          default: begin
            state_nxt = bmwo_pkg::S_IDLE;
          end
        endcase
      end

      bmwo_pkg::S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{bmwo_pkg::ST_OK, item_r.byte_address, ram_rdata,
                            1'b1, item_r.access_end, 1'b1};
          state_nxt     = bmwo_pkg::S_IDLE;
        end
      end

      bmwo_pkg::S_FRD: begin
        // skip invalid bytes, fetch the next valid one
        if (m_r[idx_r]) begin
          ram_re    = 1'b1;
          ram_raddr = {slot_r, idx_r};
          state_nxt = bmwo_pkg::S_FEM;
        end else begin
          idx_nxt = idx_p1;
        end
      end

      bmwo_pkg::S_FEM: begin
        if (out_free) begin
          m_nxt         = m_r & ~idx_bit;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{bmwo_pkg::ST_OK, {blk, idx_r}, ram_rdata, 1'b1,
                            (idx_r == bmwo_pkg::OFF_W'(bmwo_pkg::BLOCK_BYTES - 1))
                              || !m_r[idx_p1],
                            m_nxt == '0};
          if (m_nxt == '0) begin
            cmd.free_en = 1'b1;
            cmd.slot    = slot_r;
            state_nxt   = bmwo_pkg::S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = bmwo_pkg::S_FRD;
          end
        end
      end

      bmwo_pkg::S_TRUNC: begin
        cmd.trunc_en = 1'b1;
        cmd.slot     = slot_r;
        slot_nxt     = slot_r + 1'b1;
        if (slot_r == bmwo_pkg::SLOT_W'(bmwo_pkg::NUM_SLOTS - 1)) begin
          state_nxt = bmwo_pkg::S_TEM;
        end
      end

      bmwo_pkg::S_TEM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{bmwo_pkg::ST_OK, '0, 8'd0, 1'b0, 1'b0, 1'b1};
          state_nxt     = bmwo_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bmwo_pkg::S_IDLE;
      end
    endcase
  end

  // a flush walk always has a valid byte left
  a_flush_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmwo_pkg::S_FRD || state_r == bmwo_pkg::S_FEM) |-> m_r != '0)
    else $error("flush walk with empty mask");

  // store writes only come from the lookup step of a write item
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == bmwo_pkg::S_LOOK && item_r.kind == bmwo_pkg::KIND_WRITE && out_free))
    else $error("store write outside write lookup");

  // a hit read result follows a store read issued in lookup
  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmwo_pkg::S_RD && !$past(state_r == bmwo_pkg::S_RD))
      |-> $past(state_r == bmwo_pkg::S_LOOK && ram_re))
    else $error("read result without store read");

endmodule

>>> hw/rtl/bmwo_byte_ram.sv
// Generic simple dual port RAM, registered read data.
// Standalone, no package dependency.
module bmwo_byte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bmwo_slot_table.sv
// Slot table: used bits, block tags and byte valid masks, with tag match.
// Depends on bmwo_pkg.
module bmwo_slot_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bmwo_pkg::TAG_W-1:0]  look_tag,
  input  logic [bmwo_pkg::SIZE_W-1:0] dev_size,
  input  bmwo_pkg::slot_cmd_t         cmd,
  output bmwo_pkg::slot_look_t        look
);

  logic [bmwo_pkg::NUM_SLOTS-1:0]   used_r;
  logic [bmwo_pkg::TAG_W-1:0]       tag_r  [bmwo_pkg::NUM_SLOTS];
  logic [bmwo_pkg::BLOCK_BYTES-1:0] mask_r [bmwo_pkg::NUM_SLOTS];

  logic [bmwo_pkg::BLOCK_BYTES-1:0] bit_sel;
  logic [bmwo_pkg::BLOCK_BYTES-1:0] keep_mask;
  logic [bmwo_pkg::ADDR_W-1:0]      tr_base;
  logic                             tr_drop;
  logic                             tr_edge;

  // lowest matching slot and lowest free slot
  always_comb begin
    look.hit       = 1'b0;
    look.hit_slot  = '0;
    look.free_slot = '0;
    look.full      = &used_r;
    for (int s = bmwo_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
      if (used_r[s] && tag_r[s] == look_tag) begin
        look.hit      = 1'b1;
        look.hit_slot = bmwo_pkg::SLOT_W'(s);
      end
      if (!used_r[s]) begin
        look.free_slot = bmwo_pkg::SLOT_W'(s);
      end
    end
    look.hit_mask = mask_r[look.hit_slot];
  end

  always_comb begin
    bit_sel = '0;
    bit_sel[cmd.off] = 1'b1;
    tr_base = {tag_r[cmd.slot], {bmwo_pkg::OFF_W{1'b0}}};
    tr_drop = dev_size <= {1'b0, tr_base};
    tr_edge = dev_size[bmwo_pkg::SIZE_W-1:bmwo_pkg::OFF_W] == {1'b0, tag_r[cmd.slot]};
    for (int j = 0; j < bmwo_pkg::BLOCK_BYTES; j++) begin
      keep_mask[j] = bmwo_pkg::OFF_W'(j) < dev_size[bmwo_pkg::OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (cmd.wr_en) begin
        used_r[cmd.slot] <= 1'b1;
      end
      if (cmd.free_en || (cmd.trunc_en && used_r[cmd.slot] && tr_drop)) begin
        used_r[cmd.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      tag_r[cmd.slot]  <= look_tag;
      mask_r[cmd.slot] <= (cmd.wr_alloc ? '0 : mask_r[cmd.slot]) | bit_sel;
    end
    if (cmd.trunc_en && used_r[cmd.slot] && !tr_drop && tr_edge) begin
      mask_r[cmd.slot] <= mask_r[cmd.slot] & keep_mask;
    end
  end

endmodule
